// ----- sv/event_flag_group_engine_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the event flag group engine
// ---------------------------------------------------------------------------
`ifndef EVENT_FLAG_GROUP_ENGINE_UNIT_DEFINES_SVH
`define EVENT_FLAG_GROUP_ENGINE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define EFG_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("efg check failed");
// implication checked in the cycle after the antecedent
`define EFG_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("efg check failed");
`endif

// ----- sv/efg_pkg.sv -----
// ---------------------------------------------------------------------------
// efg_pkg
// Shared types and constants of the event flag group engine.
// ---------------------------------------------------------------------------
package efg_pkg;
  localparam int unsigned NumGroupsDef = 8;
  localparam int unsigned MaxWaitDef   = 4;
  localparam int unsigned FlagWidthDef = 32;

  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_DELETE = 3'd1;
  localparam logic [2:0] REQ_SET    = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_WAIT   = 3'd4;
  localparam logic [2:0] REQ_REF    = 3'd5;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD_ID   = 4'd1;
  localparam logic [3:0] ST_BAD_PAR  = 4'd2;
  localparam logic [3:0] ST_NO_GROUP = 4'd3;
  localparam logic [3:0] ST_NO_ID    = 4'd4;
  localparam logic [3:0] ST_ILLEGAL  = 4'd5;
  localparam logic [3:0] ST_TIMEOUT  = 4'd6;
  localparam logic [3:0] ST_QUEUED   = 4'd7;
  localparam logic [3:0] ST_DELETED  = 4'd8;
  localparam logic [3:0] ST_Q_FULL   = 4'd9;

  // Classified command handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_REPLY,    // reply only with the given status
    CMD_CREATE,
    CMD_DELETE,
    CMD_SET,
    CMD_CLEAR,
    CMD_WAIT,
    CMD_REF
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_REPLY
  } bk_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] status;
    logic [3:0] gid;     // zero based group index; group limit for create
    logic [31:0] pattern;
    logic       wait_all;
    logic       poll_only;
    logic [7:0] task_id;
    logic       attr_clear;
    logic       attr_multi;
  } efg_cmd_t;

  // Full-width helpers; callers truncate to FLAG_WIDTH bits.
  function automatic logic flag_match(logic [31:0] ptn, logic [31:0] wptn, logic all);
    logic hit;
    if (all) begin
      hit = ((ptn & wptn) == wptn);
    end else begin
      hit = ((ptn & wptn) != 32'd0);
    end
    return hit;
  endfunction
endpackage

// ----- sv/efg_front.sv -----
// ---------------------------------------------------------------------------
// efg_front
// Accepts requests and classifies range and parameter errors.
// ---------------------------------------------------------------------------
module efg_front import efg_pkg::*; #(
  parameter int unsigned NUM_GROUPS = NumGroupsDef,
  parameter int unsigned FLAG_WIDTH = FlagWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  groups_in_use,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [3:0]  group_id,
  input  logic [31:0] pattern,
  input  logic        wait_all,
  input  logic        poll_only,
  input  logic [7:0]  task_id,
  input  logic        attr_clear,
  input  logic        attr_multi,
  output logic        q_valid,
  input  logic        q_ready,
  output efg_cmd_t    q_data
);
  localparam logic [3:0] NgLim = 4'(NUM_GROUPS);
  localparam logic [31:0] FlagMask = 32'((64'd1 << FLAG_WIDTH) - 64'd1);

  efg_cmd_t   cls;
  logic [3:0] lim;
  logic [31:0] ptn;

  assign in_ready = !q_valid || q_ready;

  always_comb begin
    lim = (groups_in_use > NgLim) ? NgLim : groups_in_use;
    ptn = pattern & FlagMask;
    cls.status     = ST_OK;
    cls.gid        = group_id - 4'd1;
    cls.pattern    = ptn;
    cls.wait_all   = wait_all;
    cls.poll_only  = poll_only;
    cls.task_id    = task_id;
    cls.attr_clear = attr_clear;
    cls.attr_multi = attr_multi;
    cls.cmd        = CMD_REPLY;
    if (req_type > REQ_REF) begin
      cls.status = ST_BAD_PAR;
    end else if (req_type == REQ_CREATE) begin
      cls.cmd = CMD_CREATE;
      cls.gid = lim;
    end else if (group_id == 4'd0 || group_id > lim) begin
      cls.status = ST_BAD_ID;
    end else if (req_type == REQ_WAIT && ptn == 32'd0) begin
      cls.status = ST_BAD_PAR;
    end else begin
      unique case (req_type)
        REQ_DELETE: cls.cmd = CMD_DELETE;
        REQ_SET:    cls.cmd = CMD_SET;
        REQ_CLEAR:  cls.cmd = CMD_CLEAR;
        REQ_WAIT:   cls.cmd = CMD_WAIT;
        default:    cls.cmd = CMD_REF;
      endcase
    end
  end

  // one-entry queue register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      q_data <= cls;
    end
  end
endmodule

// ----- sv/efg_back.sv -----
// ---------------------------------------------------------------------------
// efg_back
// Executes classified commands on the group table and wait queues.
// ---------------------------------------------------------------------------
module efg_back import efg_pkg::*; #(
  parameter int unsigned NUM_GROUPS = NumGroupsDef,
  parameter int unsigned MAX_WAIT   = MaxWaitDef,
  parameter int unsigned FLAG_WIDTH = FlagWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  efg_cmd_t    q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_release,
  output logic [3:0]  status,
  output logic [3:0]  result_id,
  output logic [31:0] pattern_out,
  output logic [7:0]  task_out,
  output logic        last
);
  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAIT + 1);
  localparam int unsigned AW = (NUM_GROUPS * MAX_WAIT > 1) ? $clog2(NUM_GROUPS * MAX_WAIT) : 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_WAIT);

  logic                  gvalid [NUM_GROUPS];
  logic [FLAG_WIDTH-1:0] gptn   [NUM_GROUPS];
  logic [1:0]            gattr  [NUM_GROUPS];
  logic [CW-1:0]         gcnt   [NUM_GROUPS];

  // waiter memory: pattern, mode, task; one read, one write port
  logic [FLAG_WIDTH+8:0] wmem [NUM_GROUPS*MAX_WAIT];

  bk_state_t state, state_next;
  efg_cmd_t  cur;
  logic [GW-1:0] g;
  logic [CW-1:0] rd_i, wr_i;
  logic          stop;
  logic          rd_pend;
  logic [FLAG_WIDTH+8:0] rdata;
  logic [FLAG_WIDTH-1:0] ptn_now;

  logic          create_hit;
  logic [GW-1:0] create_g;
  logic          outfree;
  logic          w_hit;
  logic [FLAG_WIDTH-1:0] w_ptn;
  logic [7:0]    w_task;
  logic          w_all;

  function automatic logic [AW-1:0] widx(logic [GW-1:0] gi, logic [CW-1:0] wi);
    return AW'(gi * MAX_WAIT + wi);
  endfunction

  assign outfree = !out_valid || out_ready;
  assign q_ready = (state == BK_IDLE) && outfree;
  assign w_ptn   = rdata[FLAG_WIDTH+8:9];
  assign w_all   = rdata[8];
  assign w_task  = rdata[7:0];
  assign w_hit   = flag_match(32'(ptn_now), 32'(w_ptn), w_all);

  always_comb begin
    create_hit = 1'b0;
    create_g   = '0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if (!gvalid[i] && 4'(i) < q_data.gid) begin
        create_hit = 1'b1;
        create_g   = GW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_ready) begin
          if (q_data.cmd == CMD_DELETE || q_data.cmd == CMD_SET) begin
            state_next = BK_SCAN;
          end else if (q_data.cmd == CMD_REF && gvalid[GW'(q_data.gid)]) begin
            state_next = BK_REPLY;
          end
        end
      end
      BK_SCAN: begin
        if (rd_i >= gcnt[g] && !rd_pend && outfree) begin
          state_next = BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (outfree) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        gvalid[i] <= 1'b0;
        gptn[i]   <= '0;
        gattr[i]  <= '0;
        gcnt[i]   <= '0;
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (q_valid && q_ready) begin
            cur   <= q_data;
            g     <= GW'(q_data.gid);
            rd_i  <= '0;
            wr_i  <= '0;
            stop  <= 1'b0;
            rd_pend <= 1'b0;
            ptn_now <= gptn[GW'(q_data.gid)] | FLAG_WIDTH'(q_data.pattern);
            if (q_data.cmd == CMD_SET) begin
              gptn[GW'(q_data.gid)] <= gptn[GW'(q_data.gid)] | FLAG_WIDTH'(q_data.pattern);
            end
            if (q_data.cmd == CMD_REF && gvalid[GW'(q_data.gid)]) begin
              // fetch the head waiter; the reply follows next cycle
              rdata <= wmem[widx(GW'(q_data.gid), CW'(0))];
            end else if (q_data.cmd != CMD_DELETE && q_data.cmd != CMD_SET) begin
              out_valid   <= 1'b1;
              is_release  <= 1'b0;
              last        <= 1'b1;
              status      <= q_data.status;
              result_id   <= 4'd0;
              pattern_out <= 32'd0;
              task_out    <= 8'd0;
              if (q_data.cmd != CMD_REPLY && q_data.cmd != CMD_CREATE
                  && !gvalid[GW'(q_data.gid)]) begin
                status <= ST_NO_GROUP;
              end else begin
                unique case (q_data.cmd)
                  CMD_CREATE: begin
                    if (create_hit) begin
                      gvalid[create_g] <= 1'b1;
                      gptn[create_g]   <= FLAG_WIDTH'(q_data.pattern);
                      gattr[create_g]  <= {q_data.attr_multi, q_data.attr_clear};
                      gcnt[create_g]   <= '0;
                      result_id        <= 4'(create_g) + 4'd1;
                    end else begin
                      status <= ST_NO_ID;
                    end
                  end
                  CMD_CLEAR: begin
                    gptn[GW'(q_data.gid)] <= gptn[GW'(q_data.gid)]
                                             & FLAG_WIDTH'(q_data.pattern);
                  end
                  CMD_WAIT: begin
                    if (!gattr[GW'(q_data.gid)][1] && gcnt[GW'(q_data.gid)] != '0) begin
                      status <= ST_ILLEGAL;
                    end else if (flag_match(32'(gptn[GW'(q_data.gid)]), q_data.pattern,
                                            q_data.wait_all)) begin
                      pattern_out <= 32'(gptn[GW'(q_data.gid)]);
                      if (gattr[GW'(q_data.gid)][0]) begin
                        gptn[GW'(q_data.gid)] <= '0;
                      end
                    end else if (q_data.poll_only) begin
                      status <= ST_TIMEOUT;
                    end else if (gcnt[GW'(q_data.gid)] >= MaxCnt) begin
                      status <= ST_Q_FULL;
                    end else begin
                      status <= ST_QUEUED;
                      wmem[widx(GW'(q_data.gid), gcnt[GW'(q_data.gid)])]
                        <= {FLAG_WIDTH'(q_data.pattern), q_data.wait_all, q_data.task_id};
                      gcnt[GW'(q_data.gid)] <= gcnt[GW'(q_data.gid)] + CW'(1);
                    end
                  end
                  default: ;
                endcase
              end
            end else if (!gvalid[GW'(q_data.gid)]) begin
              // missing group: skip the scan with an empty read
              cur.status <= ST_NO_GROUP;
            end
          end
        end
        BK_SCAN: begin
          if (cur.status == ST_NO_GROUP) begin
            rd_i <= gcnt[g];
          end else if (rd_pend) begin
            if (outfree) begin
              rd_pend <= 1'b0;
              rd_i    <= rd_i + CW'(1);
              if (cur.cmd == CMD_DELETE) begin
                out_valid   <= 1'b1;
                is_release  <= 1'b1;
                last        <= 1'b0;
                status      <= ST_DELETED;
                result_id   <= 4'd0;
                pattern_out <= 32'd0;
                task_out    <= w_task;
              end else if (!stop && w_hit) begin
                out_valid   <= 1'b1;
                is_release  <= 1'b1;
                last        <= 1'b0;
                status      <= ST_OK;
                result_id   <= 4'd0;
                pattern_out <= 32'(ptn_now);
                task_out    <= w_task;
                if (gattr[g][0]) begin
                  ptn_now <= '0;
                  gptn[g] <= '0;
                  stop    <= 1'b1;
                end else if (!gattr[g][1]) begin
                  stop <= 1'b1;
                end
              end else begin
                wmem[widx(g, wr_i)] <= rdata;
                wr_i <= wr_i + CW'(1);
              end
            end
          end else if (rd_i < gcnt[g]) begin
            rdata   <= wmem[widx(g, rd_i)];
            rd_pend <= 1'b1;
          end
        end
        BK_REPLY: begin
          if (outfree) begin
            out_valid   <= 1'b1;
            is_release  <= 1'b0;
            last        <= 1'b1;
            status      <= cur.status;
            result_id   <= 4'd0;
            pattern_out <= (cur.cmd == CMD_REF) ? 32'(gptn[g]) : 32'd0;
            task_out    <= (cur.cmd == CMD_REF && gcnt[g] != '0) ? rdata[7:0] : 8'd0;
            if (cur.status != ST_NO_GROUP) begin
              if (cur.cmd == CMD_DELETE) begin
                gvalid[g] <= 1'b0;
                gptn[g]   <= '0;
                gattr[g]  <= '0;
                gcnt[g]   <= '0;
              end else if (cur.cmd == CMD_SET) begin
                gcnt[g] <= wr_i;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/event_flag_group_engine_unit.sv -----
// A simple request passes the front queue register and gets a single reply
// from BK_IDLE; a reference of a live group replies from BK_REPLY; set and
// delete read each queued waiter in BK_SCAN, then reply in BK_REPLY; result
// stalls hold these. Simple requests: one per cycle while results flow; set
// and delete hold the back end for the scan of the single-port waiter memory.
// Reset (rst, synchronous, active high): all groups invalid, queues empty,
// groups_in_use back to 8.
// ---------------------------------------------------------------------------
// event_flag_group_engine_unit
// Event flag groups with FIFO wait queues for an RTOS kernel.
// ---------------------------------------------------------------------------
`include "event_flag_group_engine_unit_defines.svh"
module event_flag_group_engine_unit import efg_pkg::*; #(
  parameter int unsigned NUM_GROUPS = NumGroupsDef,
  parameter int unsigned MAX_WAIT   = MaxWaitDef,
  parameter int unsigned FLAG_WIDTH = FlagWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [3:0]  group_id,
  input  logic [31:0] pattern,
  input  logic        wait_all,
  input  logic        poll_only,
  input  logic [7:0]  task_id,
  input  logic        attr_clear,
  input  logic        attr_multi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_release,
  output logic [3:0]  status,
  output logic [3:0]  result_id,
  output logic [31:0] pattern_out,
  output logic [7:0]  task_out,
  output logic        last
);
  logic [3:0] groups_in_use;
  logic       q_valid;
  logic       q_ready;
  efg_cmd_t   q_data;

  // hold the accepted-ID limit; write only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use <= 4'd8;
    end else if (cfg_we) begin
      groups_in_use <= cfg_wdata;
    end
  end

  // front: accept each transaction and classify it
  efg_front #(.NUM_GROUPS(NUM_GROUPS), .FLAG_WIDTH(FLAG_WIDTH)) u_front (
    .clk, .rst, .groups_in_use,
    .in_valid, .in_ready,
    .req_type, .group_id, .pattern, .wait_all, .poll_only, .task_id,
    .attr_clear, .attr_multi,
    .q_valid, .q_ready, .q_data
  );

  // back: run the command and drive result transactions
  efg_back #(.NUM_GROUPS(NUM_GROUPS), .MAX_WAIT(MAX_WAIT),
             .FLAG_WIDTH(FLAG_WIDTH)) u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready,
    .is_release, .status, .result_id, .pattern_out, .task_out, .last
  );

  `EFG_ASSERT_IMP(a_release_not_last, out_valid && is_release, !last)
  `EFG_ASSERT_IMP(a_reply_is_last, out_valid && !is_release, last)
  `EFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(task_out))
endmodule
